>>> rtl/tdcrc_pkg.sv
`default_nettype none

package tdcrc_pkg;

   // Field and table geometry
   localparam int BYTE_BITS        = 8;
   localparam int FIELD_BITS       = 64;
   localparam int TABLE_DEPTH      = 256;
   localparam int TABLE_INDEX_BITS = 8;
   localparam int WIDTH_REG_BITS   = 4;
   localparam int SHIFT_BITS       = 7;

   // Front queue geometry
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = 1;
   localparam int QUEUE_COUNT_BITS = 2;

   // Register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_WIDTH_IDX   = 1'b0;
   localparam logic CSR_REFLECT_IDX = 1'b1;

   localparam logic [WIDTH_REG_BITS-1:0] RESET_WIDTH_BYTES = 4'd4;
   localparam logic [WIDTH_REG_BITS-1:0] MIN_WIDTH_BYTES   = 4'd1;
   localparam logic [WIDTH_REG_BITS-1:0] MAX_WIDTH_BYTES   = 4'd8;

   // Request codes
   typedef enum logic [1:0] {
      OP_TABLE_WRITE = 2'd0,
      OP_SEED_LOAD   = 2'd1,
      OP_DATA_BYTE   = 2'd2,
      OP_NONE        = 2'd3
   } op_type;

   // One queued transaction
   typedef struct packed {
      op_type                      op;
      logic [TABLE_INDEX_BITS-1:0] table_index;
      logic [FIELD_BITS-1:0]       load_value;
      logic [BYTE_BITS-1:0]        data_byte;
      logic                        end_of_message;
   } item_type;

   typedef enum logic {
      ST_RUN    = 1'b0,
      ST_LOOKUP = 1'b1
   } back_state_type;

endpackage

`default_nettype wire

>>> rtl/tdcrc_ram.sv
`default_nettype none

module tdcrc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/tdcrc_front.sv
`default_nettype none

module tdcrc_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [1:0]                           req_type,
   input  wire logic [tdcrc_pkg::TABLE_INDEX_BITS-1:0] req_table_index,
   input  wire logic [tdcrc_pkg::FIELD_BITS-1:0]     req_load_value,
   input  wire logic [tdcrc_pkg::BYTE_BITS-1:0]      req_data_byte,
   input  wire logic                                 req_end_of_message,
   output logic                                      item_valid,
   output tdcrc_pkg::item_type                       item,
   input  wire logic                                 item_take
);

   tdcrc_pkg::item_type                           entries_ff [tdcrc_pkg::QUEUE_DEPTH];
   tdcrc_pkg::item_type                           req_item;
   logic [tdcrc_pkg::QUEUE_PTR_BITS-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [tdcrc_pkg::QUEUE_PTR_BITS-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [tdcrc_pkg::QUEUE_COUNT_BITS-1:0]        count_ff, count_in;
   logic                                          push;
   logic                                          pop;

   // Classify the incoming transaction
   always_comb begin
      req_item.op             = tdcrc_pkg::op_type'(req_type);
      req_item.table_index    = req_table_index;
      req_item.load_value     = req_load_value;
      req_item.data_byte      = req_data_byte;
      req_item.end_of_message = req_end_of_message;
   end

   assign req_ready  = (count_ff != tdcrc_pkg::QUEUE_COUNT_BITS'(tdcrc_pkg::QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign pop        = item_take && item_valid;
   assign item_valid = (count_ff != '0);
   assign item       = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued payload
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/tdcrc_back.sv
`default_nettype none

module tdcrc_back #(
   parameter int MAX_CRC_BITS = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   item_valid,
   input  wire tdcrc_pkg::item_type                    item,
   output logic                                        item_take,
   input  wire logic [tdcrc_pkg::WIDTH_REG_BITS-1:0]   width_bytes,
   input  wire logic                                   reflected,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [tdcrc_pkg::FIELD_BITS-1:0]            rsp_crc_value,
   output logic                                        rsp_message_done
);

   localparam logic [tdcrc_pkg::SHIFT_BITS-1:0] MaxBits =
      tdcrc_pkg::SHIFT_BITS'(MAX_CRC_BITS);
   localparam logic [tdcrc_pkg::SHIFT_BITS-1:0] ByteBits =
      tdcrc_pkg::SHIFT_BITS'(tdcrc_pkg::BYTE_BITS);
   localparam logic [tdcrc_pkg::SHIFT_BITS-1:0] FullBits =
      tdcrc_pkg::SHIFT_BITS'(tdcrc_pkg::FIELD_BITS);

   tdcrc_pkg::back_state_type                     state_ff, state_in;
   logic [MAX_CRC_BITS-1:0]                       crc_ff, crc_in;
   logic                                          eom_ff, eom_in;
   logic                                          rsp_valid_ff, rsp_valid_in;
   logic [tdcrc_pkg::FIELD_BITS-1:0]              rsp_crc_ff, rsp_crc_in;
   logic                                          rsp_done_ff, rsp_done_in;

   logic [tdcrc_pkg::WIDTH_REG_BITS-1:0]          bytes_sat;
   logic [tdcrc_pkg::SHIFT_BITS-1:0]              width_bits;
   logic [tdcrc_pkg::SHIFT_BITS-1:0]              width_lim;
   logic [tdcrc_pkg::FIELD_BITS-1:0]              mask_full;
   logic [MAX_CRC_BITS-1:0]                       mask;
   logic [MAX_CRC_BITS-1:0]                       crc_cur;
   logic [tdcrc_pkg::BYTE_BITS-1:0]               crc_byte;
   logic [tdcrc_pkg::TABLE_INDEX_BITS-1:0]        lookup_idx;
   logic [MAX_CRC_BITS-1:0]                       tbl_word;
   logic [MAX_CRC_BITS-1:0]                       crc_next;
   logic [MAX_CRC_BITS-1:0]                       seed_word;
   logic                                          out_free;

   logic                                          ram_wr_en;
   logic                                          ram_rd_en;
   logic [MAX_CRC_BITS-1:0]                       ram_rd_data;

   // Effective CRC width and mask
   always_comb begin
      priority if (width_bytes < tdcrc_pkg::MIN_WIDTH_BYTES) begin
         bytes_sat = tdcrc_pkg::MIN_WIDTH_BYTES;
      end else if (width_bytes > tdcrc_pkg::MAX_WIDTH_BYTES) begin
         bytes_sat = tdcrc_pkg::MAX_WIDTH_BYTES;
      end else begin
         bytes_sat = width_bytes;
      end
      width_bits = {bytes_sat, 3'b000};
      width_lim  = (width_bits > MaxBits) ? MaxBits : width_bits;
      mask_full  = (width_lim >= FullBits) ? '1 :
                   ((tdcrc_pkg::FIELD_BITS'(1) << width_lim) - tdcrc_pkg::FIELD_BITS'(1));
      mask       = MAX_CRC_BITS'(mask_full);
   end

   // Table index from the running CRC and the data byte
   always_comb begin
      crc_cur = crc_ff & mask;
      if (reflected) begin
         crc_byte = crc_cur[tdcrc_pkg::BYTE_BITS-1:0];
      end else begin
         crc_byte = tdcrc_pkg::BYTE_BITS'(crc_cur >> (width_lim - ByteBits));
      end
      lookup_idx = crc_byte ^ item.data_byte;
      seed_word  = MAX_CRC_BITS'(item.load_value) & mask;
   end

   // Fold the table word into the CRC
   always_comb begin
      tbl_word = ram_rd_data & mask;
      if (reflected) begin
         crc_next = ((crc_cur >> tdcrc_pkg::BYTE_BITS) ^ tbl_word) & mask;
      end else begin
         crc_next = ((crc_cur << tdcrc_pkg::BYTE_BITS) ^ tbl_word) & mask;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequence one transaction at a time
   always_comb begin
      state_in     = state_ff;
      crc_in       = crc_ff;
      eom_in       = eom_ff;
      item_take    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_crc_in   = rsp_crc_ff;
      rsp_done_in  = rsp_done_ff;
      unique case (state_ff)
         tdcrc_pkg::ST_RUN: begin
            if (item_valid) begin
               unique case (item.op)
                  tdcrc_pkg::OP_TABLE_WRITE: begin
                     if (out_free) begin
                        item_take    = 1'b1;
                        ram_wr_en    = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_crc_in   = tdcrc_pkg::FIELD_BITS'(crc_cur);
                        rsp_done_in  = 1'b0;
                     end
                  end
                  tdcrc_pkg::OP_SEED_LOAD: begin
                     if (out_free) begin
                        item_take    = 1'b1;
                        crc_in       = seed_word;
                        rsp_valid_in = 1'b1;
                        rsp_crc_in   = tdcrc_pkg::FIELD_BITS'(seed_word);
                        rsp_done_in  = 1'b0;
                     end
                  end
                  tdcrc_pkg::OP_DATA_BYTE: begin
                     item_take = 1'b1;
                     ram_rd_en = 1'b1;
                     eom_in    = item.end_of_message;
                     state_in  = tdcrc_pkg::ST_LOOKUP;
                  end
                  tdcrc_pkg::OP_NONE: begin
                     if (out_free) begin
                        item_take    = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_crc_in   = tdcrc_pkg::FIELD_BITS'(crc_cur);
                        rsp_done_in  = 1'b0;
                     end
                  end
                  default: begin
                     item_take = 1'b0;
                  end
               endcase
            end
         end
         tdcrc_pkg::ST_LOOKUP: begin
            if (out_free) begin
               crc_in       = crc_next;
               rsp_valid_in = 1'b1;
               rsp_crc_in   = tdcrc_pkg::FIELD_BITS'(crc_next);
               rsp_done_in  = eom_ff;
               state_in     = tdcrc_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = tdcrc_pkg::ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdcrc_pkg::ST_RUN;
         crc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eom_ff      <= eom_in;
      rsp_crc_ff  <= rsp_crc_in;
      rsp_done_ff <= rsp_done_in;
   end

   // Lookup table
   tdcrc_ram #(
      .WIDTH (MAX_CRC_BITS),
      .DEPTH (tdcrc_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (item.table_index),
      .wr_data (seed_word),
      .rd_en   (ram_rd_en),
      .rd_addr (lookup_idx),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_crc_value    = rsp_crc_ff;
   assign rsp_message_done = rsp_done_ff;

endmodule

`default_nettype wire

>>> rtl/table_driven_crc_update.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  type, table index, load value, data byte, eom
// rsp       out        rsp_valid/rsp_ready  crc value, message done
// csr       in         APB write/read       width in bytes, reflected mode
//
// A table write, seed load or unused code completes in the back end's run state; a data
// byte also needs the lookup state, because its table index comes from the running CRC
// and the table memory has a registered read. No new item is taken during that lookup.
// A two-entry queue lets requests arrive while the back end or result register stalls.
// Reset is synchronous: CRC cleared, width 4 bytes, normal mode; the table is not cleared.
`default_nettype none

module table_driven_crc_update #(
   parameter int MAX_CRC_BITS = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [1:0]                             req_type,
   input  wire logic [tdcrc_pkg::TABLE_INDEX_BITS-1:0] req_table_index,
   input  wire logic [tdcrc_pkg::FIELD_BITS-1:0]       req_load_value,
   input  wire logic [tdcrc_pkg::BYTE_BITS-1:0]        req_data_byte,
   input  wire logic                                   req_end_of_message,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [tdcrc_pkg::FIELD_BITS-1:0]            rsp_crc_value,
   output logic                                        rsp_message_done,
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [tdcrc_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [tdcrc_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [tdcrc_pkg::CSR_DATA_BITS-1:0]         csr_prdata,
   output logic                                        csr_pready
);

   logic [tdcrc_pkg::WIDTH_REG_BITS-1:0] width_ff, width_in;
   logic                                 reflect_ff, reflect_in;
   logic                                 csr_write;
   logic                                 csr_idx;
   logic                                 item_valid;
   logic                                 item_take;
   tdcrc_pkg::item_type                  item;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[2];

   // Register writes
   always_comb begin
      width_in   = width_ff;
      reflect_in = reflect_ff;
      if (csr_write) begin
         unique case (csr_idx)
            tdcrc_pkg::CSR_WIDTH_IDX:   width_in   = csr_pwdata[tdcrc_pkg::WIDTH_REG_BITS-1:0];
            tdcrc_pkg::CSR_REFLECT_IDX: reflect_in = csr_pwdata[0];
            default:                    width_in   = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= tdcrc_pkg::RESET_WIDTH_BYTES;
         reflect_ff <= 1'b0;
      end else begin
         width_ff   <= width_in;
         reflect_ff <= reflect_in;
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_idx)
         tdcrc_pkg::CSR_WIDTH_IDX:   csr_prdata = tdcrc_pkg::CSR_DATA_BITS'(width_ff);
         tdcrc_pkg::CSR_REFLECT_IDX: csr_prdata = tdcrc_pkg::CSR_DATA_BITS'(reflect_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   tdcrc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_table_index    (req_table_index),
      .req_load_value     (req_load_value),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .item_valid         (item_valid),
      .item               (item),
      .item_take          (item_take)
   );

   tdcrc_back #(
      .MAX_CRC_BITS (MAX_CRC_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take),
      .width_bytes      (width_ff),
      .reflected        (reflect_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_crc_value    (rsp_crc_value),
      .rsp_message_done (rsp_message_done)
   );

endmodule

`default_nettype wire

>>> tb/sv/crc_update_checker.sv
`timescale 1ns / 1ps

module crc_update_checker
   import tdcrc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [1:0]                  req_type,
   input  logic [TABLE_INDEX_BITS-1:0] req_table_index,
   input  logic [FIELD_BITS-1:0]       req_load_value,
   input  logic [BYTE_BITS-1:0]        req_data_byte,
   input  logic                        req_end_of_message,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [FIELD_BITS-1:0]       rsp_crc_value,
   input  logic                        rsp_message_done,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic                        csr_pready,
   input  logic [CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]    csr_pwdata,
   output int                          mismatches,
   output int                          outstanding
);

   localparam logic [CSR_ADDR_BITS-1:0] WIDTH_ADDR   = {CSR_WIDTH_IDX, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] REFLECT_ADDR = {CSR_REFLECT_IDX, 2'b00};

   typedef struct packed {
      logic [FIELD_BITS-1:0] crc;
      logic                  done;
   } crc_result_type;

   // Shadow copy of the engine state and its registers
   logic [FIELD_BITS-1:0]     shadow_lut [TABLE_DEPTH];
   logic [FIELD_BITS-1:0]     crc_now = '0;
   logic [WIDTH_REG_BITS-1:0] width_bytes = RESET_WIDTH_BYTES;
   logic                      reflect_on = 1'b0;
   crc_result_type            crc_expected_q [$];
   int                        error_count = 0;
   int                        pending_count = 0;

   assign mismatches  = error_count;
   assign outstanding = pending_count;

   // Fold one request into the shadow state and return the result it should produce
   function automatic crc_result_type fold_crc_item(op_type op,
                                                    logic [TABLE_INDEX_BITS-1:0] idx,
                                                    logic [FIELD_BITS-1:0] val,
                                                    logic [BYTE_BITS-1:0] data, logic eom);
      logic [WIDTH_REG_BITS-1:0] bytes_used;
      int unsigned               bits;
      logic [FIELD_BITS-1:0]     mask;
      logic [FIELD_BITS-1:0]     c;
      logic [BYTE_BITS-1:0]      lookup;
      crc_result_type            r;
      bytes_used = width_bytes;
      if (bytes_used < MIN_WIDTH_BYTES) bytes_used = MIN_WIDTH_BYTES;
      if (bytes_used > MAX_WIDTH_BYTES) bytes_used = MAX_WIDTH_BYTES;
      bits = bytes_used * BYTE_BITS;
      mask = (bits >= FIELD_BITS) ? '1 : ((64'd1 << bits) - 64'd1);
      r.done = 1'b0;
      case (op)
         OP_TABLE_WRITE: shadow_lut[idx] = val & mask;
         OP_SEED_LOAD:   crc_now = val & mask;
         OP_DATA_BYTE: begin
            c = crc_now & mask;
            if (reflect_on) begin
               lookup = c[BYTE_BITS-1:0] ^ data;
               c = (c >> BYTE_BITS) ^ (shadow_lut[lookup] & mask);
            end else begin
               lookup = 8'(c >> (bits - BYTE_BITS)) ^ data;
               c = (c << BYTE_BITS) ^ (shadow_lut[lookup] & mask);
            end
            crc_now = c & mask;
            r.done  = eom;
         end
         OP_NONE: ;
         default: ;
      endcase
      r.crc = crc_now & mask;
      return r;
   endfunction

   function automatic void note_error(string msg);
      if (error_count < 10) $display("%t %s", $realtime, msg);
      error_count++;
   endfunction

   always @(posedge clock) begin
      crc_result_type want;
      if (reset) begin
         crc_now     = '0;
         width_bytes = RESET_WIDTH_BYTES;
         reflect_on  = 1'b0;
         crc_expected_q.delete();
      end else begin
         // Match a returned transaction against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (crc_expected_q.size() == 0) begin
               note_error($sformatf("unexpected crc result: crc %h done %b",
                                    rsp_crc_value, rsp_message_done));
            end else begin
               want = crc_expected_q.pop_front();
               if (rsp_crc_value !== want.crc || rsp_message_done !== want.done)
                  note_error($sformatf("crc result mismatch: expected crc %h done %b, got crc %h done %b",
                                       want.crc, want.done, rsp_crc_value, rsp_message_done));
            end
         end
         // Predict the result of an accepted request
         if (req_valid && req_ready)
            crc_expected_q.push_back(fold_crc_item(op_type'(req_type), req_table_index,
                                                   req_load_value, req_data_byte,
                                                   req_end_of_message));
         // Track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               WIDTH_ADDR:   width_bytes = csr_pwdata[WIDTH_REG_BITS-1:0];
               REFLECT_ADDR: reflect_on = csr_pwdata[0];
               default: ;
            endcase
         end
      end
      pending_count <= crc_expected_q.size();
   end

endmodule

>>> tb/sv/table_driven_crc_update_tb.sv
`timescale 1ns / 1ps

module table_driven_crc_update_tb;
   import tdcrc_pkg::*;

   localparam int RANDOM_ITEMS = 1070;
   localparam int PHASES       = 12;
   localparam logic [CSR_ADDR_BITS-1:0] WIDTH_ADDR   = {CSR_WIDTH_IDX, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] REFLECT_ADDR = {CSR_REFLECT_IDX, 2'b00};

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_type = OP_NONE;
   logic [TABLE_INDEX_BITS-1:0] req_table_index = '0;
   logic [FIELD_BITS-1:0]       req_load_value = '0;
   logic [BYTE_BITS-1:0]        req_data_byte = '0;
   logic                        req_end_of_message = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [FIELD_BITS-1:0]       rsp_crc_value;
   logic                        rsp_message_done;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]    csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]    csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]    csr_prdata;
   logic                        csr_pready;

   int mismatches;
   int outstanding;
   int sent_count = 0;
   bit quiet = 1'b0;

   table_driven_crc_update dut (.*);

   crc_update_checker crc_check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the handshakes hang
   initial begin
      #5ms;
      $display("table_driven_crc_update verification failed");
      $finish;
   end

   // Result side: stall a random number of cycles before taking each transaction
   initial begin
      int unsigned hold;
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 11);
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic logic [FIELD_BITS-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Present one request after a random gap and hold it until accepted
   task automatic send_request(input op_type op, input logic [TABLE_INDEX_BITS-1:0] idx,
                               input logic [FIELD_BITS-1:0] val,
                               input logic [BYTE_BITS-1:0] data, input logic eom);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= op;
      req_table_index    <= idx;
      req_load_value     <= val;
      req_data_byte      <= data;
      req_end_of_message <= eom;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // Hold off new requests until every predicted result has come back
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_register(input logic [CSR_ADDR_BITS-1:0] addr,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Random upper bits ride along with each register value
   task automatic set_mode(input logic [WIDTH_REG_BITS-1:0] bytes, input logic reflect);
      write_register(WIDTH_ADDR, {$urandom} & ~32'hF | bytes);
      write_register(REFLECT_ADDR, {$urandom} & ~32'h1 | reflect);
   endtask

   task automatic send_message(input int unsigned len, input bit with_seed);
      int unsigned k;
      logic [FIELD_BITS-1:0] seed;
      case ($urandom_range(0, 7))
         0: seed = '0;
         1: seed = '1;
         default: seed = rand64();
      endcase
      if (with_seed)
         send_request(OP_SEED_LOAD, 8'($urandom), seed, 8'($urandom), 1'($urandom));
      for (k = 0; k < len; k++)
         send_request(OP_DATA_BYTE, 8'($urandom), rand64(), 8'($urandom), k == len - 1);
   endtask

   initial begin
      int i;
      int phase;
      int random_start;
      int unsigned pick;
      int unsigned len;
      logic [WIDTH_REG_BITS-1:0] bytes;
      logic reflect;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: seed masking and the unused code
      send_request(OP_SEED_LOAD, 8'h00, '1, 8'h00, 1'b0);
      send_request(OP_NONE, '1, '1, '1, 1'b1);
      send_request(OP_NONE, '0, '0, '0, 1'b0);
      send_request(OP_SEED_LOAD, '1, rand64(), '1, 1'b1);

      // Fill the whole table at full width so no lookup ever hits an unwritten entry
      wait_results_drained();
      set_mode(4'd8, 1'b0);
      for (i = 0; i < TABLE_DEPTH; i++)
         send_request(OP_TABLE_WRITE, i[TABLE_INDEX_BITS-1:0], rand64(), 8'($urandom),
                      1'($urandom));

      // Directed bytes at the reset width in normal mode
      wait_results_drained();
      set_mode(RESET_WIDTH_BYTES, 1'b0);
      send_request(OP_SEED_LOAD, 8'h00, '0, 8'h00, 1'b0);
      send_request(OP_DATA_BYTE, 8'h00, '0, 8'h00, 1'b0);
      send_request(OP_DATA_BYTE, '1, '1, 8'hFF, 1'b1);
      send_request(OP_TABLE_WRITE, 8'h00, '1, 8'h00, 1'b1);
      send_request(OP_TABLE_WRITE, 8'hFF, '0, 8'hFF, 1'b0);
      send_request(OP_SEED_LOAD, 8'h00, '1, 8'h00, 1'b0);
      send_request(OP_DATA_BYTE, 8'h00, '0, 8'hFF, 1'b1);
      send_request(OP_DATA_BYTE, 8'h00, '0, 8'h00, 1'b0);
      send_request(OP_TABLE_WRITE, 8'h80, 64'h8000_0000_0000_0001, 8'h00, 1'b0);
      send_request(OP_DATA_BYTE, '1, '1, 8'h5A, 1'b1);
      send_message(4, 1'b1);

      // Random phases, each under its own register setting; the CRC carries across
      random_start = sent_count;
      for (phase = 0; phase < PHASES; phase++) begin
         wait_results_drained();
         case (phase)
            0: begin bytes = 4'd1;  reflect = 1'b0; end
            1: begin bytes = 4'd1;  reflect = 1'b1; end
            2: begin bytes = 4'd8;  reflect = 1'b0; end
            3: begin bytes = 4'd8;  reflect = 1'b1; end
            4: begin bytes = 4'd0;  reflect = 1'b1; end
            5: begin bytes = 4'd15; reflect = 1'b0; end
            6: begin bytes = 4'd12; reflect = 1'b1; end
            7: begin bytes = 4'd0;  reflect = 1'b0; end
            default: begin
               bytes   = 4'($urandom_range(0, 15));
               reflect = 1'($urandom);
            end
         endcase
         set_mode(bytes, reflect);
         quiet = ($urandom_range(0, 3) == 0);
         while (sent_count - random_start < (phase + 1) * RANDOM_ITEMS / PHASES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               // well-formed message, occasionally continuing the previous CRC
               len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
               send_message(len, $urandom_range(0, 4) != 0);
            end else if (pick < 82) begin
               send_request(OP_TABLE_WRITE, 8'($urandom), rand64(), 8'($urandom),
                            1'($urandom));
            end else if (pick < 91) begin
               send_request(OP_NONE, 8'($urandom), rand64(), 8'($urandom), 1'($urandom));
            end else if (pick < 97) begin
               // broken message: stray marks, no clean end
               len = $urandom_range(1, 4);
               repeat (len)
                  send_request(OP_DATA_BYTE, 8'($urandom), rand64(), 8'($urandom),
                               1'($urandom));
            end else begin
               wait_results_drained();
            end
            if ($urandom_range(0, 15) == 0) quiet = !quiet;
         end
      end

      // Drain, let the pipeline settle, then give the verdict
      wait_results_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("table_driven_crc_update verification clean");
      end else begin
         $display("table_driven_crc_update verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/tdcrc_pkg.sv
rtl/tdcrc_ram.sv
rtl/tdcrc_front.sv
rtl/tdcrc_back.sv
rtl/table_driven_crc_update.sv
tb/sv/crc_update_checker.sv
tb/sv/table_driven_crc_update_tb.sv
